### sv/bco_pkg.sv
// Shared constants for the box/circle overlap test: field widths, defaults
// and the fixed-point sine coefficients. No dependencies.
package bco_pkg;

  localparam int unsigned MASK_W      = 32;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned SIZE_W      = 31;
  localparam int unsigned ANGLE_IN_W  = 16;
  localparam int unsigned QUO_W       = 32;
  localparam int unsigned TRIG_SHIFT  = 30;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0] Q30_ROUND = 32'h3FFF_FFFF;
  localparam logic [31:0] TRIG_C1   = 32'd1686629713;
  localparam logic [31:0] TRIG_C3   = 32'd693598669;
  localparam logic [31:0] TRIG_C5   = 32'd85569305;
  localparam logic [31:0] TRIG_C7   = 32'd5026994;
  localparam logic [31:0] TRIG_C9   = 32'd172272;

endpackage

### sv/bco_in_if.sv
// Input channel of the overlap test: one collider pair per word.
// Depends on bco_pkg.
interface bco_in_if import bco_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MASK_W-1:0]          box_mask;
  logic [MASK_W-1:0]          circle_mask;
  logic signed [COORD_W-1:0]  box_x;
  logic signed [COORD_W-1:0]  box_y;
  logic [ANGLE_IN_W-1:0]      box_angle;
  logic signed [COORD_W-1:0]  box_scale_x;
  logic signed [COORD_W-1:0]  box_scale_y;
  logic [SIZE_W-1:0]          box_width;
  logic [SIZE_W-1:0]          box_height;
  logic signed [COORD_W-1:0]  circle_x;
  logic signed [COORD_W-1:0]  circle_y;
  logic [SIZE_W-1:0]          circle_radius;

  modport source (
    output valid, box_mask, circle_mask, box_x, box_y, box_angle, box_scale_x,
           box_scale_y, box_width, box_height, circle_x, circle_y, circle_radius,
    input  ready
  );
  modport sink (
    input  valid, box_mask, circle_mask, box_x, box_y, box_angle, box_scale_x,
           box_scale_y, box_width, box_height, circle_x, circle_y, circle_radius,
    output ready
  );
endinterface

### sv/bco_out_if.sv
// Result channel of the overlap test: hit and scale error flags per word.
// Depends on bco_pkg.
interface bco_out_if import bco_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;
  logic scale_error;

  modport source (output valid, hit, scale_error, input ready);
  modport sink (input valid, hit, scale_error, output ready);
endinterface

### sv/box_circle_overlap_test.sv
// channel  dir  modport  word
// in_i     in   sink     masks, box pose/scale/size, circle centre/radius
// out_o    out  source   hit, scale_error
//
// One word accepted per cycle unless a result word is stalled at the output; the
// 32-stage restoring quotient chain follows the 6-stage sine/cosine pipeline.
// Reset clears only the per-stage valid bits.
// A result word waiting at the output holds the whole pipeline; nothing is
// dropped or repeated. Depends on bco_pkg, bco_in_if, bco_out_if.
module box_circle_overlap_test import bco_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bco_in_if.sink    in_i,
  bco_out_if.source out_o
);

  localparam int unsigned QW  = ANGLE_BITS - 2;
  localparam int unsigned KW  = QW + 1;
  localparam int unsigned XSH = 32 - ANGLE_BITS;

  localparam logic [ANGLE_BITS-1:0] QUARTER_P = ANGLE_BITS'(1) << QW;
  localparam logic [KW-1:0]         QUARTER_K = KW'(1) << QW;

  localparam int unsigned ST_SQ      = 1;
  localparam int unsigned ST_H_FIRST = 2;
  localparam int unsigned ST_H_LAST  = 5;
  localparam int unsigned ST_OVF     = 2;
  localparam int unsigned ST_DINIT   = 3;
  localparam int unsigned ST_SIN     = 6;
  localparam int unsigned ST_DIV0    = 7;
  localparam int unsigned ST_DIV_END = ST_DIV0 + QUO_W - 1;
  localparam int unsigned ST_SGN     = ST_DIV_END + 1;
  localparam int unsigned ST_MUL     = ST_SGN + 1;
  localparam int unsigned ST_SUM     = ST_MUL + 1;
  localparam int unsigned ST_SHR     = ST_SUM + 1;
  localparam int unsigned ST_ABS     = ST_SHR + 1;
  localparam int unsigned ST_EXC     = ST_ABS + 1;
  localparam int unsigned ST_SQR     = ST_EXC + 1;
  localparam int unsigned ST_CMP     = ST_SQR + 1;
  localparam int unsigned NST        = ST_CMP + 1;

  typedef struct packed {
    logic                 act;
    logic                 serr;
    logic                 hit;
    logic                 ovx;
    logic                 ovy;
    logic                 big;
    logic                 negqx;
    logic                 negqy;
    logic                 ssx;
    logic                 ssy;
    logic                 ns;
    logic                 nc;
    logic [KW-1:0]        ks;
    logic [KW-1:0]        kc;
    logic [31:0]          xs;
    logic [31:0]          xc;
    logic [31:0]          x2s;
    logic [31:0]          x2c;
    logic [31:0]          ts;
    logic [31:0]          tc;
    logic signed [31:0]   sv;
    logic signed [31:0]   cv;
    logic signed [32:0]   ox;
    logic signed [32:0]   oy;
    logic [31:0]          dmx;
    logic [31:0]          dmy;
    logic [32:0]          ax;
    logic [32:0]          ay;
    logic [31:0]          remx;
    logic [31:0]          remy;
    logic [31:0]          dlx;
    logic [31:0]          dly;
    logic [QUO_W-1:0]     qx;
    logic [QUO_W-1:0]     qy;
    logic signed [32:0]   qsx;
    logic signed [32:0]   qsy;
    logic signed [64:0]   pxc;
    logic signed [64:0]   pys;
    logic signed [64:0]   pyc;
    logic signed [64:0]   pxs;
    logic signed [65:0]   sumx;
    logic signed [65:0]   sumy;
    logic signed [35:0]   rx;
    logic signed [35:0]   ry;
    logic [35:0]          abx;
    logic [35:0]          aby;
    logic [29:0]          hw;
    logic [29:0]          hh;
    logic [30:0]          rad;
    logic [35:0]          ex;
    logic [35:0]          ey;
    logic [61:0]          ex2;
    logic [61:0]          ey2;
    logic [61:0]          rad2;
  } item_t;

  function automatic logic [KW-1:0] quarter_k(input logic [ANGLE_BITS-1:0] pp);
    logic [KW-1:0] kk;
    kk = {1'b0, pp[QW-1:0]};
    if (pp[QW]) begin
      kk = QUARTER_K - kk;
    end
    return kk;
  endfunction

  function automatic logic [31:0] horner_coef(input int unsigned st);
    logic [31:0] cf;
    case (st)
      2:       cf = TRIG_C7;
      3:       cf = TRIG_C5;
      4:       cf = TRIG_C3;
      default: cf = TRIG_C1;
    endcase
    return cf;
  endfunction

  function automatic item_t step(input int unsigned st, input item_t i);
    item_t                o;
    logic [63:0]          prs;
    logic [63:0]          prc;
    logic [63:0]          nw;
    logic [31:0]          tq;
    logic [32:0]          tt;
    logic                 ge;
    logic signed [65:0]   tmp;
    o = i;
    if (st == ST_SQ) begin
      o.xs  = 32'(i.ks) << XSH;
      o.xc  = 32'(i.kc) << XSH;
      prs   = 64'(o.xs) * 64'(o.xs);
      prc   = 64'(o.xc) * 64'(o.xc);
      o.x2s = 32'(prs >> TRIG_SHIFT);
      o.x2c = 32'(prc >> TRIG_SHIFT);
      o.ts  = TRIG_C9;
      o.tc  = TRIG_C9;
      o.ax  = i.ox[32] ? 33'(-i.ox) : 33'(i.ox);
      o.ay  = i.oy[32] ? 33'(-i.oy) : 33'(i.oy);
      o.negqx = i.ox[32] ^ i.ssx;
      o.negqy = i.oy[32] ^ i.ssy;
    end
    if (st >= ST_H_FIRST && st <= ST_H_LAST) begin
      prs  = 64'(i.x2s) * 64'(i.ts);
      prc  = 64'(i.x2c) * 64'(i.tc);
      o.ts = horner_coef(st) - 32'(prs >> TRIG_SHIFT);
      o.tc = horner_coef(st) - 32'(prc >> TRIG_SHIFT);
    end
    if (st == ST_OVF) begin
      o.ovx = {31'b0, i.ax} >= (64'(i.dmx) << (32 - FRAC_BITS));
      o.ovy = {31'b0, i.ay} >= (64'(i.dmy) << (32 - FRAC_BITS));
    end
    if (st == ST_DINIT) begin
      nw     = 64'(i.ax) << FRAC_BITS;
      o.remx = nw[63:32];
      o.dlx  = nw[31:0];
      nw     = 64'(i.ay) << FRAC_BITS;
      o.remy = nw[63:32];
      o.dly  = nw[31:0];
      o.qx   = '0;
      o.qy   = '0;
    end
    if (st == ST_SIN) begin
      prs = 64'(i.xs) * 64'(i.ts);
      tq  = 32'(prs >> TRIG_SHIFT);
      if (tq > ONE_Q30) begin
        tq = ONE_Q30;
      end
      o.sv = i.ns ? -$signed(tq) : $signed(tq);
      prc = 64'(i.xc) * 64'(i.tc);
      tq  = 32'(prc >> TRIG_SHIFT);
      if (tq > ONE_Q30) begin
        tq = ONE_Q30;
      end
      o.cv = i.nc ? -$signed(tq) : $signed(tq);
    end
    if (st >= ST_DIV0 && st <= ST_DIV_END) begin
      tt     = {i.remx, i.dlx[31]};
      ge     = tt >= {1'b0, i.dmx};
      o.remx = ge ? 32'(tt - {1'b0, i.dmx}) : tt[31:0];
      o.dlx  = i.dlx << 1;
      o.qx   = {i.qx[QUO_W-2:0], ge};
      tt     = {i.remy, i.dly[31]};
      ge     = tt >= {1'b0, i.dmy};
      o.remy = ge ? 32'(tt - {1'b0, i.dmy}) : tt[31:0];
      o.dly  = i.dly << 1;
      o.qy   = {i.qy[QUO_W-2:0], ge};
    end
    if (st == ST_SGN) begin
      o.qsx = i.negqx ? -$signed({1'b0, i.qx}) : $signed({1'b0, i.qx});
      o.qsy = i.negqy ? -$signed({1'b0, i.qy}) : $signed({1'b0, i.qy});
    end
    if (st == ST_MUL) begin
      o.pxc = i.qsx * i.cv;
      o.pys = i.qsy * i.sv;
      o.pyc = i.qsy * i.cv;
      o.pxs = i.qsx * i.sv;
    end
    if (st == ST_SUM) begin
      o.sumx = i.pxc + i.pys;
      o.sumy = i.pyc - i.pxs;
    end
    if (st == ST_SHR) begin
      tmp  = i.sumx[65] ? i.sumx + $signed({34'b0, Q30_ROUND}) : i.sumx;
      o.rx = 36'(tmp >>> TRIG_SHIFT);
      tmp  = i.sumy[65] ? i.sumy + $signed({34'b0, Q30_ROUND}) : i.sumy;
      o.ry = 36'(tmp >>> TRIG_SHIFT);
    end
    if (st == ST_ABS) begin
      o.abx = i.rx[35] ? 36'(-i.rx) : 36'(i.rx);
      o.aby = i.ry[35] ? 36'(-i.ry) : 36'(i.ry);
    end
    if (st == ST_EXC) begin
      o.ex  = (i.abx > 36'(i.hw)) ? i.abx - 36'(i.hw) : '0;
      o.ey  = (i.aby > 36'(i.hh)) ? i.aby - 36'(i.hh) : '0;
    end
    if (st == ST_SQR) begin
      o.big  = (i.ex > 36'(i.rad)) || (i.ey > 36'(i.rad));
      o.ex2  = i.ex[30:0] * i.ex[30:0];
      o.ey2  = i.ey[30:0] * i.ey[30:0];
      o.rad2 = i.rad * i.rad;
    end
    if (st == ST_CMP) begin
      o.hit = i.act && !i.ovx && !i.ovy && !i.big &&
              (({1'b0, i.ex2} + {1'b0, i.ey2}) <= {1'b0, i.rad2});
    end
    return o;
  endfunction

  item_t          nxt [NST];
  item_t          dq  [NST];
  logic [NST-1:0] vq;
  logic           en;

  assign en          = !vq[NST-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vq[NST-1];
  assign out_o.hit   = dq[NST-1].hit;
  assign out_o.scale_error = dq[NST-1].serr;

  always_comb begin
    logic [ANGLE_IN_W+ANGLE_BITS-1:0] pa;
    logic [ANGLE_BITS-1:0]            p;
    logic [ANGLE_BITS-1:0]            pc;
    logic                             mk;
    logic                             zx;
    logic                             zy;
    nxt[0]      = '0;
    mk          = |(in_i.box_mask & in_i.circle_mask);
    zx          = in_i.box_scale_x == '0;
    zy          = in_i.box_scale_y == '0;
    nxt[0].act  = mk && !zx && !zy;
    nxt[0].serr = mk && (zx || zy);
    nxt[0].ox   = {in_i.circle_x[31], in_i.circle_x} - {in_i.box_x[31], in_i.box_x};
    nxt[0].oy   = {in_i.circle_y[31], in_i.circle_y} - {in_i.box_y[31], in_i.box_y};
    nxt[0].ssx  = in_i.box_scale_x[31];
    nxt[0].ssy  = in_i.box_scale_y[31];
    nxt[0].dmx  = in_i.box_scale_x[31] ? 32'(-in_i.box_scale_x) : in_i.box_scale_x;
    nxt[0].dmy  = in_i.box_scale_y[31] ? 32'(-in_i.box_scale_y) : in_i.box_scale_y;
    pa          = {in_i.box_angle, ANGLE_BITS'(0)};
    p           = pa[ANGLE_IN_W+ANGLE_BITS-1 -: ANGLE_BITS];
    pc          = p + QUARTER_P;
    nxt[0].ks   = quarter_k(p);
    nxt[0].kc   = quarter_k(pc);
    nxt[0].ns   = p[ANGLE_BITS-1];
    nxt[0].nc   = pc[ANGLE_BITS-1];
    nxt[0].hw   = in_i.box_width[30:1];
    nxt[0].hh   = in_i.box_height[30:1];
    nxt[0].rad  = in_i.circle_radius;
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    assign nxt[g] = step(g, dq[g-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[NST-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        dq[s] <= nxt[s];
      end
    end
  end

endmodule

### sv/bco_checker.sv
// Port-level checks for box_circle_overlap_test and the bind that attaches them.
// Depends on box_circle_overlap_test.
module bco_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic hit_i,
  input logic scale_error_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(hit_i) && $stable(scale_error_i))
    else $error("result word changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_i && scale_error_i))
    else $error("hit reported with scale error");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while pipeline is stalled");

endmodule

bind box_circle_overlap_test bco_checker u_bco_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .hit_i         (out_o.hit),
  .scale_error_i (out_o.scale_error)
);
